/* design/nbvu_pkg.sv */
// shared constants and types for the n-body velocity update block
`default_nettype none

package nbvu_pkg;

    localparam int MAX_BODIES = 64;
    localparam int IDX_W      = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
    localparam int COUNT_W    = $clog2(MAX_BODIES + 1);

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 62;
    localparam int PAIR_LAT   = 5 + SQRT_STEPS + DIV_STEPS;
    localparam int DRAIN_W    = $clog2(PAIR_LAT + 2);

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_COMPUTE = 2'd1;
    localparam logic [1:0] KIND_CLEAR   = 2'd2;
    localparam logic [1:0] KIND_SPARE   = 2'd3;

    localparam logic CFG_TIME_STEP = 1'b0;
    localparam logic CFG_SOFTENING = 1'b1;

    localparam logic [30:0] TIME_STEP_RESET = 31'd655;
    localparam logic [16:0] SOFTENING_RESET = 17'd1;

    // x in the top word, z in the bottom word
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_t;

    typedef struct packed {
        logic valid;
        pos_t src;
    } pair_in_t;

    typedef struct packed {
        logic                            valid;
        logic                            kill;
        logic [2:0]                      neg;
        logic [2:0][DIV_STEPS-1:0]       q;
    } pair_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

/* design/nbvu_cell.sv */
// one source table cell of the rotating position ring
`default_nettype none

module nbvu_cell (
    input  wire logic         clk,
    input  wire logic         shift_en,
    input  wire logic         wr_en,
    input  wire nbvu_pkg::pos_t wr_pos,
    input  wire nbvu_pkg::pos_t prev_pos,
    output nbvu_pkg::pos_t    pos
);

    nbvu_pkg::pos_t pos_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pos_reg <= wr_pos;
        end
        else if (shift_en)
        begin
            pos_reg <= prev_pos;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

/* design/nbvu_pair.sv */
// pipelined pair interaction: distance, square root, denominator and three divides
`default_nettype none

module nbvu_pair (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nbvu_pkg::pair_in_t in_item,
    input  wire nbvu_pkg::pos_t     tgt,
    input  wire logic [16:0]        softening,
    output nbvu_pkg::pair_out_t     out_item
);

    localparam int SQ = nbvu_pkg::SQRT_STEPS;
    localparam int DV = nbvu_pkg::DIV_STEPS;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
    } s1_t;

    typedef struct packed {
        logic             valid;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic [2:0][47:0] sq;
    } s2_t;

    typedef struct packed {
        logic             valid;
        logic             far;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic [46:0]      d;
        logic [63:0]      v;
        logic [35:0]      rem;
        logic [31:0]      root;
    } sq_t;

    typedef struct packed {
        logic             valid;
        logic             far;
        logic [2:0]       neg;
        logic [2:0][31:0] m;
        logic [63:0]      pl;
        logic [46:0]      ph;
    } ma_t;

    typedef struct packed {
        logic               valid;
        logic               kill;
        logic [2:0]         neg;
        logic [DV-1:0]      dvs;
        logic [2:0][DV-1:0] rem;
        logic [2:0][DV-1:0] nq;
    } dv_t;

    function automatic sq_t sqrt_step(input sq_t s);
        sq_t         r;
        logic [35:0] rem2;
        logic [35:0] trial;
        r     = s;
        rem2  = {s.rem[33:0], s.v[63:62]};
        trial = {2'b00, s.root, 2'b01};
        if (rem2 >= trial)
        begin
            r.rem  = rem2 - trial;
            r.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = rem2;
            r.root = {s.root[30:0], 1'b0};
        end
        r.v = {s.v[61:0], 2'b00};
        return r;
    endfunction

    function automatic dv_t div_step(input dv_t s);
        dv_t       r;
        logic [DV:0] t;
        r = s;
        for (int a = 0; a < 3; a++)
        begin
            t = {s.rem[a], s.nq[a][DV-1]};
            if (t >= {1'b0, s.dvs})
            begin
                r.rem[a] = DV'(t - {1'b0, s.dvs});
                r.nq[a]  = {s.nq[a][DV-2:0], 1'b1};
            end
            else
            begin
                r.rem[a] = t[DV-1:0];
                r.nq[a]  = {s.nq[a][DV-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic [2:0][31:0] src_c;
    logic [2:0][31:0] tgt_c;

    s1_t s1_next, s1_reg;
    s2_t s2_next, s2_reg;
    sq_t sq_first;
    sq_t sq_reg [SQ];
    sq_t sq_in  [SQ];
    ma_t ma_next, ma_reg;
    dv_t dv_first;
    dv_t dv_reg [DV];
    dv_t dv_in  [DV];

    assign src_c = in_item.src;
    assign tgt_c = tgt;

    // distance components
    always_comb
    begin
        logic [32:0] diff;
        logic [32:0] mag33;
        s1_next.valid = in_item.valid;
        for (int a = 0; a < 3; a++)
        begin
            diff             = {src_c[a][31], src_c[a]} - {tgt_c[a][31], tgt_c[a]};
            mag33            = diff[32] ? (33'd0 - diff) : diff;
            s1_next.neg[a]   = diff[32];
            s1_next.m[a]     = mag33[31:0];
        end
    end

    // squares
    always_comb
    begin
        logic [63:0] p;
        s2_next.valid = s1_reg.valid;
        s2_next.neg   = s1_reg.neg;
        s2_next.m     = s1_reg.m;
        for (int a = 0; a < 3; a++)
        begin
            p              = 64'(s1_reg.m[a]) * 64'(s1_reg.m[a]);
            s2_next.sq[a]  = p[63:16];
        end
    end

    // squared distance plus softening, far pair check
    always_comb
    begin
        logic [49:0] dsum;
        dsum = 50'(s2_reg.sq[2]) + 50'(s2_reg.sq[1]) + 50'(s2_reg.sq[0])
             + 50'(softening);
        sq_first.valid = s2_reg.valid;
        sq_first.far   = |dsum[49:47];
        sq_first.neg   = s2_reg.neg;
        sq_first.m     = s2_reg.m;
        sq_first.d     = dsum[46:0];
        sq_first.v     = {1'b0, dsum[46:0], 16'd0};
        sq_first.rem   = '0;
        sq_first.root  = '0;
    end

    genvar i;
    generate
        for (i = 0; i < SQ; i++)
        begin : g_sqrt
            if (i == 0)
            begin : g_first
                assign sq_in[i] = sq_first;
            end
            else
            begin : g_next
                assign sq_in[i] = sq_reg[i-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    sq_reg[i] <= '0;
                end
                else
                begin
                    sq_reg[i] <= sqrt_step(sq_in[i]);
                end
            end
        end
    endgenerate

    // denominator partial products
    always_comb
    begin
        ma_next.valid = sq_reg[SQ-1].valid;
        ma_next.far   = sq_reg[SQ-1].far;
        ma_next.neg   = sq_reg[SQ-1].neg;
        ma_next.m     = sq_reg[SQ-1].m;
        ma_next.pl    = 64'(sq_reg[SQ-1].d[31:0]) * 64'(sq_reg[SQ-1].root);
        ma_next.ph    = 47'(sq_reg[SQ-1].d[46:32]) * 47'(sq_reg[SQ-1].root);
    end

    always_comb
    begin
        logic [78:0] den;
        den = {15'd0, ma_reg.pl} + {ma_reg.ph, 32'd0};
        dv_first.valid = ma_reg.valid;
        dv_first.neg   = ma_reg.neg;
        dv_first.dvs   = den[63:2];
        dv_first.kill  = ma_reg.far || (|den[78:64]) || (den[63:2] == '0);
        dv_first.rem   = '0;
        for (int a = 0; a < 3; a++)
        begin
            dv_first.nq[a] = {ma_reg.m[a], 30'd0};
        end
    end

    generate
        for (i = 0; i < DV; i++)
        begin : g_div
            if (i == 0)
            begin : g_first
                assign dv_in[i] = dv_first;
            end
            else
            begin : g_next
                assign dv_in[i] = dv_reg[i-1];
            end
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_reg[i] <= '0;
                end
                else
                begin
                    dv_reg[i] <= div_step(dv_in[i]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
            s2_reg <= '0;
            ma_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            ma_reg <= ma_next;
        end
    end

    assign out_item.valid = dv_reg[DV-1].valid;
    assign out_item.kill  = dv_reg[DV-1].kill;
    assign out_item.neg   = dv_reg[DV-1].neg;
    assign out_item.q     = dv_reg[DV-1].nq;

endmodule

`default_nettype wire

/* design/nbody_velocity_update_top.sv */
// top level: source ring, pair pipeline, accumulators, dt scaling and output register
// load and clear are done when accepted; a compute item rotates the ring once
// through the 97-stage pair pipeline, then drains, scales by dt and writes the
// output register
// reset empties the table, sets time_step to 655 and softening to 1
`default_nettype none

module nbody_velocity_update_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         kind,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] pos_z,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic signed [31:0] vel_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      new_vel_x,
    output logic signed [31:0]      new_vel_y,
    output logic signed [31:0]      new_vel_z,
    output logic                    saturated,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [31:0]        cfg_data
);

    localparam int MAXB    = nbvu_pkg::MAX_BODIES;
    localparam int IDX_W   = nbvu_pkg::IDX_W;
    localparam int COUNT_W = nbvu_pkg::COUNT_W;
    localparam int DRAIN_W = nbvu_pkg::DRAIN_W;
    localparam int DV      = nbvu_pkg::DIV_STEPS;

    typedef struct packed {
        logic        sat;
        logic [31:0] val;
    } clip_t;

    function automatic clip_t clip32(input logic [64:0] v);
        clip_t r;
        if (!v[64] && (|v[63:31]))
        begin
            r.sat = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end
        else if (v[64] && !(&v[63:31]))
        begin
            r.sat = 1'b1;
            r.val = 32'h8000_0000;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = v[31:0];
        end
        return r;
    endfunction

    nbvu_pkg::state_t    state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg;
    logic [IDX_W-1:0]    step_reg;
    logic [DRAIN_W-1:0]  drain_reg;
    logic [30:0]         time_step_reg;
    logic [16:0]         softening_reg;
    nbvu_pkg::pos_t      tgt_reg;
    logic [2:0][31:0]    vel_reg;
    logic [2:0][31:0]    acc_reg;
    logic                sat_reg;
    logic [2:0][62:0]    prod_reg;
    logic [2:0]          prod_neg_reg;
    logic [2:0][31:0]    nv_reg;
    logic                sat_out_reg;
    logic                out_valid_reg;

    logic                in_accept;
    logic                load_en;
    logic                out_free;
    nbvu_pkg::pos_t      load_pos;
    nbvu_pkg::pos_t      cell_pos [MAXB];
    nbvu_pkg::pair_in_t  pair_in;
    nbvu_pkg::pair_out_t pair_out;
    clip_t [2:0]         acc_clip;
    clip_t [2:0]         nv_clip;

    assign in_stall  = (state_reg != nbvu_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_pos  = '{x: pos_x, y: pos_y, z: pos_z};
    assign load_en   = in_accept && (kind == nbvu_pkg::KIND_LOAD)
                     && (count_reg < COUNT_W'(MAXB));

    genvar k;
    generate
        for (k = 0; k < MAXB; k++)
        begin : g_cell
            nbvu_cell u_cell (
                .clk      (clk),
                .shift_en (state_reg == nbvu_pkg::ST_RUN),
                .wr_en    (load_en && (count_reg[IDX_W-1:0] == IDX_W'(k))),
                .wr_pos   (load_pos),
                .prev_pos (cell_pos[(k + 1) % MAXB]),
                .pos      (cell_pos[k])
            );
        end
    endgenerate

    assign pair_in.valid = (state_reg == nbvu_pkg::ST_RUN)
                         && ({1'b0, step_reg} < count_reg);
    assign pair_in.src   = cell_pos[0];

    nbvu_pair u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (pair_in),
        .tgt       (tgt_reg),
        .softening (softening_reg),
        .out_item  (pair_out)
    );

    // saturating accumulation of one source term per axis
    always_comb
    begin
        logic [64:0] ext;
        logic [64:0] tq;
        for (int a = 0; a < 3; a++)
        begin
            ext         = {{33{acc_reg[a][31]}}, acc_reg[a]};
            tq          = {{(65 - DV){1'b0}}, pair_out.q[a]};
            acc_clip[a] = clip32(pair_out.neg[a] ? (ext - tq) : (ext + tq));
        end
    end

    // velocity plus scaled force
    always_comb
    begin
        logic [48:0] delta;
        logic [48:0] p;
        for (int a = 0; a < 3; a++)
        begin
            p          = {2'b00, prod_reg[a][62:16]};
            delta      = prod_neg_reg[a] ? (49'd0 - p) : p;
            nv_clip[a] = clip32({{33{vel_reg[a][31]}}, vel_reg[a]}
                                + {{16{delta[48]}}, delta});
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nbvu_pkg::ST_IDLE:
            begin
                if (in_accept && (kind == nbvu_pkg::KIND_COMPUTE))
                begin
                    state_next = nbvu_pkg::ST_RUN;
                end
            end
            nbvu_pkg::ST_RUN:
            begin
                if (step_reg == IDX_W'(MAXB - 1))
                begin
                    state_next = nbvu_pkg::ST_DRAIN;
                end
            end
            nbvu_pkg::ST_DRAIN:
            begin
                if (drain_reg == DRAIN_W'(nbvu_pkg::PAIR_LAT + 1))
                begin
                    state_next = nbvu_pkg::ST_SCALE;
                end
            end
            nbvu_pkg::ST_SCALE:
            begin
                state_next = nbvu_pkg::ST_FINISH;
            end
            nbvu_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = nbvu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = nbvu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbvu_pkg::ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            drain_reg     <= '0;
            time_step_reg <= nbvu_pkg::TIME_STEP_RESET;
            softening_reg <= nbvu_pkg::SOFTENING_RESET;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    nbvu_pkg::CFG_TIME_STEP: time_step_reg <= cfg_data[30:0];
                    nbvu_pkg::CFG_SOFTENING: softening_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end

            if (in_accept)
            begin
                unique case (kind)
                    nbvu_pkg::KIND_LOAD:
                    begin
                        if (load_en)
                        begin
                            count_reg <= count_reg + COUNT_W'(1);
                        end
                    end
                    nbvu_pkg::KIND_COMPUTE:
                    begin
                        acc_reg  <= '0;
                        sat_reg  <= 1'b0;
                        step_reg <= '0;
                    end
                    nbvu_pkg::KIND_CLEAR:
                    begin
                        count_reg <= '0;
                    end
                    default: ;
                endcase
            end

            if (state_reg == nbvu_pkg::ST_RUN)
            begin
                step_reg  <= step_reg + IDX_W'(1);
                drain_reg <= '0;
            end
            if (state_reg == nbvu_pkg::ST_DRAIN)
            begin
                drain_reg <= drain_reg + DRAIN_W'(1);
            end

            if (pair_out.valid && !pair_out.kill)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    acc_reg[a] <= acc_clip[a].val;
                end
                if (acc_clip[0].sat || acc_clip[1].sat || acc_clip[2].sat)
                begin
                    sat_reg <= 1'b1;
                end
            end

            if ((state_reg == nbvu_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        logic [32:0] am;
        if (in_accept && (kind == nbvu_pkg::KIND_COMPUTE))
        begin
            tgt_reg <= load_pos;
            vel_reg <= {vel_x, vel_y, vel_z};
        end
        if (state_reg == nbvu_pkg::ST_SCALE)
        begin
            for (int a = 0; a < 3; a++)
            begin
                am              = acc_reg[a][31] ? (33'd0 - {1'b1, acc_reg[a]})
                                                 : {1'b0, acc_reg[a]};
                prod_reg[a]     <= 63'(time_step_reg) * 63'(am[31:0]);
                prod_neg_reg[a] <= acc_reg[a][31];
            end
        end
        if ((state_reg == nbvu_pkg::ST_FINISH) && out_free)
        begin
            for (int a = 0; a < 3; a++)
            begin
                nv_reg[a] <= nv_clip[a].val;
            end
            sat_out_reg <= sat_reg || nv_clip[0].sat || nv_clip[1].sat || nv_clip[2].sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign new_vel_x = nv_reg[2];
    assign new_vel_y = nv_reg[1];
    assign new_vel_z = nv_reg[0];
    assign saturated = sat_out_reg;

    a_pair_window: assert property (@(posedge clk) disable iff (!rst_n)
        pair_out.valid |-> (state_reg == nbvu_pkg::ST_RUN || state_reg == nbvu_pkg::ST_DRAIN))
        else $error("pair result outside run or drain");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAXB))
        else $error("source count beyond table size");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == nbvu_pkg::ST_FINISH)
        else $error("result shown without finishing a compute");

    a_table_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == nbvu_pkg::ST_RUN |=> $stable(count_reg))
        else $error("table size changed during rotation");

endmodule

`default_nettype wire
